>>> rtl/svm_pkg.sv
// Shared types, constants and helpers for the sample playback voice mixer.
package svm_pkg;

    // Field widths of the beats and registers
    localparam int MIX_IN_W    = 24;
    localparam int SAMPLE_W    = 16;
    localparam int ADDR_IN_W   = 16;
    localparam int RATE_W      = 24;
    localparam int LEN_W       = 17;
    localparam int VOL_W       = 16;
    localparam int PAN_W       = 16;
    localparam int START_W     = 32;
    localparam int FRAME_W     = 2 * SAMPLE_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Position is signed Q24.16
    localparam int POS_W  = 40;
    localparam int FRAC_W = 16;

    // Q1.15 arithmetic
    localparam int GAIN_W  = 17;
    localparam int Q_SHIFT = 15;
    localparam int Q_HALF  = 16384;
    localparam logic [VOL_W-1:0]  VOL_UNITY  = 16'h8000;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h08000;

    // Width used for mix sums before saturation (covers MIX_WIDTH up to 32)
    localparam int SUM_W = 34;

    // Mode codes of the input beat
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_STEP      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_FRAMES  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_ENABLE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAN            = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO         = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 3'd6;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [ADDR_IN_W-1:0]        sample_address;
        logic signed [SAMPLE_W-1:0]  sample_left;
        logic signed [SAMPLE_W-1:0]  sample_right;
        logic signed [MIX_IN_W-1:0]  in_left;
        logic signed [MIX_IN_W-1:0]  in_right;
    } item_t;

    typedef struct packed {
        logic signed [MIX_IN_W-1:0]  out_left;
        logic signed [MIX_IN_W-1:0]  out_right;
        logic                        still_playing;
    } result_t;

    typedef struct packed {
        logic signed [RATE_W-1:0]    rate_step;
        logic [LEN_W-1:0]            length_frames;
        logic                        loop_enable;
        logic [VOL_W-1:0]            volume;
        logic signed [PAN_W-1:0]     pan;
        logic                        stereo;
        logic [START_W-1:0]          start_position;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rate_step:      24'sd65536,
        length_frames:  17'd0,
        loop_enable:    1'b0,
        volume:         VOL_UNITY,
        pan:            16'sd0,
        stereo:         1'b1,
        start_position: 32'd0
    };

    // Command classes passed from the front to the back
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [ADDR_IN_W-1:0]        sample_address;
        logic [FRAME_W-1:0]          frame;      // right in the upper half
        logic signed [MIX_IN_W-1:0]  mix_left;   // already saturated
        logic signed [MIX_IN_W-1:0]  mix_right;
    } cmd_t;

    // Clamp a sum to a signed range of the given width
    function automatic logic signed [SUM_W-1:0] sat_mix(
        input logic signed [SUM_W-1:0] v,
        input int                      width
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed((SUM_W'(1) << (width - 1)) - SUM_W'(1));
        lo = ~hi;
        if (v > hi) begin
            return hi;
        end
        else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

>>> rtl/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/svm_front.sv
// Front end: takes input beats, classifies them and queues commands for the back end.
module svm_front #(
    parameter int FRAME_DEPTH = 65536,
    parameter int MIX_WIDTH   = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  svm_pkg::item_t  item,
    output logic            cmd_valid,
    output svm_pkg::cmd_t   cmd,
    input  logic            cmd_pop
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);
    localparam int SUM_W  = svm_pkg::SUM_W;
    localparam int MIX_W  = svm_pkg::MIX_IN_W;

    svm_pkg::cmd_t           new_cmd;
    logic                    keep;
    logic                    push;
    logic signed [SUM_W-1:0] left_sat;
    logic signed [SUM_W-1:0] right_sat;

    svm_pkg::cmd_t           q_reg [QDEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [CNT_W-1:0]        count_reg;

    // incoming sums are clamped to the mix range before anything is added
    assign left_sat  = svm_pkg::sat_mix(SUM_W'(item.in_left), MIX_WIDTH);
    assign right_sat = svm_pkg::sat_mix(SUM_W'(item.in_right), MIX_WIDTH);

    // classify the beat; loads beyond the memory are dropped here
    always_comb
    begin
        new_cmd                = '0;
        new_cmd.sample_address = item.sample_address;
        new_cmd.frame          = {item.sample_right, item.sample_left};
        new_cmd.mix_left       = left_sat[MIX_W-1:0];
        new_cmd.mix_right      = right_sat[MIX_W-1:0];
        keep                   = 1'b1;
        unique case (item.mode)
            svm_pkg::MODE_LOAD:
            begin
                new_cmd.kind = svm_pkg::CMD_LOAD;
                keep         = 32'(item.sample_address) < 32'(FRAME_DEPTH);
            end
            svm_pkg::MODE_START: new_cmd.kind = svm_pkg::CMD_START;
            svm_pkg::MODE_STOP:  new_cmd.kind = svm_pkg::CMD_STOP;
            svm_pkg::MODE_TICK:  new_cmd.kind = svm_pkg::CMD_TICK;
            default:             keep = 1'b0;
        endcase
    end

    // command queue
    assign item_ready = count_reg != CNT_W'(QDEPTH);
    assign push       = item_valid && item_ready && keep;
    assign cmd_valid  = count_reg != '0;
    assign cmd        = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (!push && cmd_pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("command queue over its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cmd_pop) |=> (count_reg != '0))
        else $error("queued command lost");

endmodule

>>> rtl/svm_back.sv
// Back end: sample memory, play position, remainder unit and mixing datapath.
module svm_back #(
    parameter int FRAME_DEPTH = 65536,
    parameter int MIX_WIDTH   = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  svm_pkg::cfg_t     cfg,
    input  logic              cmd_valid,
    input  svm_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    output logic              result_valid,
    input  logic              result_ready,
    output svm_pkg::result_t  result
);

    localparam int AW        = $clog2(FRAME_DEPTH);
    localparam int POS_W     = svm_pkg::POS_W;
    localparam int FRAC_W    = svm_pkg::FRAC_W;
    localparam int INT_W     = POS_W - FRAC_W;
    localparam int LEN_W     = svm_pkg::LEN_W;
    localparam int GAIN_W    = svm_pkg::GAIN_W;
    localparam int GP_W      = 2 * GAIN_W;
    localparam int SAMPLE_W  = svm_pkg::SAMPLE_W;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int CONTRIB_W = PROD_W - svm_pkg::Q_SHIFT;
    localparam int SUM_W     = svm_pkg::SUM_W;
    localparam int MIX_W     = svm_pkg::MIX_IN_W;
    localparam int FRAME_W   = svm_pkg::FRAME_W;
    localparam int DIV_STEPS = INT_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_READ  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [POS_W-1:0]           pos_reg;
    logic                       playing_reg;
    logic                       out_valid_reg;
    svm_pkg::result_t           out_reg;
    svm_pkg::result_t           res_reg;
    logic signed [MIX_W-1:0]    mix_l_reg;
    logic signed [MIX_W-1:0]    mix_r_reg;
    logic [GAIN_W-1:0]          gain_l_reg;
    logic [GAIN_W-1:0]          gain_r_reg;
    logic signed [PROD_W-1:0]   prod_l_reg;
    logic signed [PROD_W-1:0]   prod_r_reg;
    logic [LEN_W-1:0]           rem_reg;
    logic [INT_W-1:0]           num_reg;
    logic [CNT_W-1:0]           div_cnt_reg;

    logic [LEN_W-1:0]           len_eff;
    logic                       pos_neg;
    logic                       past_end;
    logic                       wrap_ok;
    logic                       out_free;
    logic [svm_pkg::VOL_W-1:0]  vol_eff;
    logic [GAIN_W-1:0]          fade_l;
    logic [GAIN_W-1:0]          fade_r;
    logic [GP_W-1:0]            gain_l_full;
    logic [GP_W-1:0]            gain_r_full;
    logic [FRAME_W-1:0]         ram_rdata;
    logic                       ram_we;
    logic signed [SAMPLE_W-1:0] smp_l;
    logic signed [SAMPLE_W-1:0] smp_r;
    logic signed [PROD_W-1:0]   prod_l;
    logic signed [PROD_W-1:0]   prod_r;
    logic signed [PROD_W-1:0]   rnd_l;
    logic signed [PROD_W-1:0]   rnd_r;
    logic signed [CONTRIB_W-1:0] contrib_l;
    logic signed [CONTRIB_W-1:0] contrib_r;
    logic signed [SUM_W-1:0]    sat_l;
    logic signed [SUM_W-1:0]    sat_r;
    logic [LEN_W:0]             div_t1;
    logic [LEN_W:0]             div_t2;
    logic [LEN_W-1:0]           rem_next;

    // sample memory, left in the low half of each frame
    svm_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frames (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(cmd.sample_address)),
        .wdata (cmd.frame),
        .raddr (pos_reg[FRAC_W +: AW]),
        .rdata (ram_rdata)
    );

    // settings derived from the configuration
    assign len_eff  = (32'(cfg.length_frames) > 32'(FRAME_DEPTH)) ?
                      LEN_W'(FRAME_DEPTH) : cfg.length_frames;
    assign pos_neg  = pos_reg[POS_W-1];
    assign past_end = pos_reg[POS_W-2:FRAC_W] >= (INT_W-1)'(len_eff);
    assign wrap_ok  = cfg.loop_enable && (len_eff != '0);
    assign out_free = !out_valid_reg || result_ready;
    assign vol_eff  = (cfg.volume > svm_pkg::VOL_UNITY) ? svm_pkg::VOL_UNITY : cfg.volume;

    // balance: positive pan fades left, negative pan fades right
    assign fade_l = (!cfg.pan[svm_pkg::PAN_W-1] && cfg.pan != '0) ?
                    svm_pkg::GAIN_UNITY - GAIN_W'(cfg.pan) : svm_pkg::GAIN_UNITY;
    assign fade_r = cfg.pan[svm_pkg::PAN_W-1] ?
                    svm_pkg::GAIN_UNITY + GAIN_W'(cfg.pan) : svm_pkg::GAIN_UNITY;

    assign gain_l_full = GP_W'(vol_eff) * GP_W'(fade_l) + GP_W'(svm_pkg::Q_HALF);
    assign gain_r_full = GP_W'(vol_eff) * GP_W'(fade_r) + GP_W'(svm_pkg::Q_HALF);

    // sample times gain
    assign smp_l  = $signed(ram_rdata[SAMPLE_W-1:0]);
    assign smp_r  = cfg.stereo ? $signed(ram_rdata[FRAME_W-1:SAMPLE_W]) : smp_l;
    assign prod_l = smp_l * $signed({1'b0, gain_l_reg});
    assign prod_r = smp_r * $signed({1'b0, gain_r_reg});

    // round half up back to Q1.15, add and clamp
    assign rnd_l     = prod_l_reg + PROD_W'(svm_pkg::Q_HALF);
    assign rnd_r     = prod_r_reg + PROD_W'(svm_pkg::Q_HALF);
    assign contrib_l = $signed(rnd_l[PROD_W-1:svm_pkg::Q_SHIFT]);
    assign contrib_r = $signed(rnd_r[PROD_W-1:svm_pkg::Q_SHIFT]);
    assign sat_l = svm_pkg::sat_mix(SUM_W'(mix_l_reg) + SUM_W'(contrib_l), MIX_WIDTH);
    assign sat_r = svm_pkg::sat_mix(SUM_W'(mix_r_reg) + SUM_W'(contrib_r), MIX_WIDTH);

    // remainder unit: two restoring steps per cycle on the integer position
    always_comb
    begin
        div_t1 = {rem_reg, num_reg[INT_W-1]};
        if (div_t1 >= {1'b0, len_eff})
        begin
            div_t1 = div_t1 - {1'b0, len_eff};
        end
        div_t2 = {div_t1[LEN_W-1:0], num_reg[INT_W-2]};
        if (div_t2 >= {1'b0, len_eff})
        begin
            div_t2 = div_t2 - {1'b0, len_eff};
        end
        rem_next = div_t2[LEN_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == svm_pkg::CMD_TICK)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (!playing_reg || pos_neg)
                begin
                    state_next = S_FIN;
                end
                else if (past_end)
                begin
                    state_next = wrap_ok ? S_DIV : S_FIN;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign ram_we = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == svm_pkg::CMD_LOAD);

    // voice state and output beat control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            playing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && cmd_valid)
            begin
                unique case (cmd.kind)
                    svm_pkg::CMD_START:
                    begin
                        pos_reg     <= POS_W'(cfg.start_position);
                        playing_reg <= 1'b1;
                    end
                    svm_pkg::CMD_STOP: playing_reg <= 1'b0;
                    default: ;
                endcase
            end
            if (state_reg == S_CHECK && (pos_neg || (past_end && !wrap_ok)))
            begin
                playing_reg <= 1'b0;
            end
            if (state_reg == S_DIV && div_cnt_reg == '0)
            begin
                pos_reg <= POS_W'({rem_next, pos_reg[FRAC_W-1:0]});
            end
            if (state_reg == S_SUM)
            begin
                pos_reg <= pos_reg + POS_W'(cfg.rate_step);
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            mix_l_reg <= cmd.mix_left;
            mix_r_reg <= cmd.mix_right;
        end
        if (state_reg == S_CHECK)
        begin
            gain_l_reg  <= gain_l_full[svm_pkg::Q_SHIFT +: GAIN_W];
            gain_r_reg  <= gain_r_full[svm_pkg::Q_SHIFT +: GAIN_W];
            num_reg     <= {1'b0, pos_reg[POS_W-2:FRAC_W]};
            rem_reg     <= '0;
            div_cnt_reg <= CNT_W'(DIV_STEPS - 1);
            res_reg     <= '{out_left: mix_l_reg, out_right: mix_r_reg, still_playing: 1'b0};
        end
        if (state_reg == S_DIV)
        begin
            num_reg     <= num_reg << 2;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
        if (state_reg == S_MUL)
        begin
            prod_l_reg <= prod_l;
            prod_r_reg <= prod_r;
        end
        if (state_reg == S_SUM)
        begin
            res_reg <= '{out_left:      sat_l[MIX_W-1:0],
                         out_right:     sat_r[MIX_W-1:0],
                         still_playing: 1'b1};
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (playing_reg && !pos_neg && !past_end))
        else $error("frame read outside the sample");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE && cmd_valid))
        else $error("command taken while busy");

    a_playing_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && res_reg.still_playing) |-> playing_reg)
        else $error("playing result from a stopped voice");

    a_wrap_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cfg.loop_enable && len_eff != '0))
        else $error("wrap without looping");

endmodule

>>> rtl/sample_voice_mixer.sv
// Top level of the sample playback voice mixer: configuration registers and the two halves.
//
// One playback voice over a FRAME_DEPTH-frame stereo sample memory (a RAM that is not
// cleared; frames must be loaded before they are played). Beats on the item channel
// load frames, start or stop the voice, or ask for one mix tick; only ticks give a
// result beat, carrying the incoming sums plus this voice, clamped to MIX_WIDTH bits.
// Items land in a two-deep command queue and are run one at a time by the back end: load,
// start and stop are handled in the idle state; an idle tick runs position check and
// delivery, a playing tick position check, gains, registered memory read, multiply, add
// and clamp and delivery; a tick that wraps a looping voice first works out the remainder
// of the integer position, two bits per cycle. The user must write registers through
// cfg_write, cfg_index and cfg_data only while no item is in flight; not enforced here.
module sample_voice_mixer #(
    parameter int FRAME_DEPTH = 65536,
    parameter int MIX_WIDTH   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  svm_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output svm_pkg::result_t                    result,
    input  logic                                cfg_write,
    input  logic [svm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [svm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    svm_pkg::cfg_t  cfg_reg;
    logic           cmd_valid;
    svm_pkg::cmd_t  cmd;
    logic           cmd_pop;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= svm_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                svm_pkg::REG_RATE_STEP:
                    cfg_reg.rate_step <= cfg_data[svm_pkg::RATE_W-1:0];
                svm_pkg::REG_LENGTH_FRAMES:
                    cfg_reg.length_frames <= cfg_data[svm_pkg::LEN_W-1:0];
                svm_pkg::REG_LOOP_ENABLE:
                    cfg_reg.loop_enable <= cfg_data[0];
                svm_pkg::REG_VOLUME:
                    cfg_reg.volume <= cfg_data[svm_pkg::VOL_W-1:0];
                svm_pkg::REG_PAN:
                    cfg_reg.pan <= cfg_data[svm_pkg::PAN_W-1:0];
                svm_pkg::REG_STEREO:
                    cfg_reg.stereo <= cfg_data[0];
                svm_pkg::REG_START_POSITION:
                    cfg_reg.start_position <= cfg_data[svm_pkg::START_W-1:0];
                default: ;
            endcase
        end
    end

    svm_front #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .MIX_WIDTH   (MIX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    svm_back #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .MIX_WIDTH   (MIX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
